// ===== hdl/stun_mapped_address_parser_defines.svh =====
// Assertion helpers for the one block that checks itself.
// Each macro expects clk and rst_n in scope.
`ifndef STUN_MAPPED_ADDRESS_PARSER_DEFINES_SVH
`define STUN_MAPPED_ADDRESS_PARSER_DEFINES_SVH

// Same-cycle implication.
`define SMAP_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("smap assertion failed");

// Next-cycle implication.
`define SMAP_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("smap assertion failed");

`endif

// ===== hdl/smap_pkg.sv =====
`default_nettype none
package smap_pkg;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic        address_valid;
        logic [15:0] mapped_port;
        logic [31:0] mapped_ipv4;
    } out_t;

    // request kinds
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_ARM  = 2'd1;
    localparam logic [1:0] REQ_DROP = 2'd2;

    // parse phases
    localparam logic [2:0] PH_HEADER      = 3'd0;
    localparam logic [2:0] PH_ATTR_HDR    = 3'd1;
    localparam logic [2:0] PH_ATTR_SKIP   = 3'd2;
    localparam logic [2:0] PH_ATTR_MAPPED = 3'd3;
    localparam logic [2:0] PH_FINISHED    = 3'd4;

    // verdicts
    localparam logic [2:0] VERDICT_IDLE     = 3'd0;
    localparam logic [2:0] VERDICT_HEADER   = 3'd1;
    localparam logic [2:0] VERDICT_ATTR_LEN = 3'd2;
    localparam logic [2:0] VERDICT_NO_ADDR  = 3'd3;
    localparam logic [2:0] VERDICT_CAPTURED = 3'd4;

    // protocol constants
    localparam logic [15:0] BIND_RESPONSE = 16'h0101;
    localparam logic [31:0] MAGIC_COOKIE  = 32'h2112A442;
    localparam logic [15:0] ATTR_MAPPED   = 16'h0001;
    localparam logic [15:0] ALIGN_MASK    = 16'h0003;

    // byte positions and counts
    localparam logic [15:0] POS_METHOD_LO  = 16'd1;
    localparam logic [15:0] POS_LENGTH_LO  = 16'd3;
    localparam logic [15:0] POS_COOKIE_LO  = 16'd7;
    localparam logic [15:0] POS_HEADER_END = 16'd19;
    localparam logic [15:0] POS_SATURATED  = 16'hFFFF;
    localparam logic [15:0] ATTR_HDR_BYTES = 16'd4;
    localparam logic [15:0] MAPPED_BYTES   = 16'd8;
    localparam logic [15:0] MAPPED_PORT_AT = 16'd5;

endpackage
`default_nettype wire

// ===== hdl/smap_parse.sv =====
`default_nettype none
module smap_parse (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         take,
    input  wire smap_pkg::in_t req,
    output logic              res_valid,
    output smap_pkg::out_t    res
);
    import smap_pkg::*;

    logic        pending_reg,   pending_next;
    logic        responded_reg, responded_next;
    logic [15:0] pos_reg,       pos_next;
    logic [15:0] msg_left_reg,  msg_left_next;
    logic [15:0] attr_type_reg, attr_type_next;
    logic [15:0] attr_left_reg, attr_left_next;
    logic [2:0]  phase_reg,     phase_next;
    logic [31:0] shift_reg,     shift_next;
    logic [15:0] port_reg,      port_next;
    logic [31:0] addr_reg,      addr_next;
    logic [2:0]  verdict_reg,   verdict_next;

    always_comb
    begin
        logic [31:0] sw;
        logic [15:0] len;
        logic [15:0] ml4;
        logic [15:0] al;
        logic        walk_on;
        logic [15:0] walk_left;

        pending_next   = pending_reg;
        responded_next = responded_reg;
        pos_next       = pos_reg;
        msg_left_next  = msg_left_reg;
        attr_type_next = attr_type_reg;
        attr_left_next = attr_left_reg;
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        port_next      = port_reg;
        addr_next      = addr_reg;
        verdict_next   = verdict_reg;
        res_valid      = 1'b0;
        res            = '0;
        sw             = {shift_reg[23:0], req.data_byte};
        len            = sw[15:0];
        ml4            = msg_left_reg - ATTR_HDR_BYTES;
        al             = attr_left_reg - 16'd1;
        walk_on        = 1'b0;
        walk_left      = msg_left_reg;

        if (take)
        begin
            unique case (req.req_type)
                REQ_ARM:
                begin
                    if (!pending_reg)
                    begin
                        pending_next   = 1'b1;
                        responded_next = 1'b0;
                        if (pos_reg != 16'd0)
                        begin
                            phase_next   = PH_FINISHED;
                            verdict_next = VERDICT_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                end
                REQ_DROP:
                begin
                    pending_next   = 1'b0;
                    responded_next = 1'b0;
                    port_next      = '0;
                    addr_next      = '0;
                    if (pos_reg != 16'd0)
                    begin
                        phase_next   = PH_FINISHED;
                        verdict_next = VERDICT_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                REQ_BYTE:
                begin
                    // first byte decides whether this datagram is parsed
                    if (pos_reg == 16'd0)
                    begin
                        if (pending_reg && !responded_reg)
                        begin
                            phase_next   = PH_HEADER;
                            verdict_next = VERDICT_HEADER;
                        end
                        else
                        begin
                            phase_next   = PH_FINISHED;
                            verdict_next = VERDICT_IDLE;
                        end
                    end
                    if (pos_reg != POS_SATURATED)
                        pos_next = pos_reg + 16'd1;

                    if (phase_next != PH_FINISHED)
                    begin
                        shift_next = sw;
                        unique case (phase_next)
                            PH_HEADER:
                            begin
                                priority if (pos_reg == POS_METHOD_LO
                                             && sw[15:0] != BIND_RESPONSE)
                                begin
                                    phase_next   = PH_FINISHED;
                                    verdict_next = VERDICT_HEADER;
                                end
                                else if (pos_reg == POS_LENGTH_LO)
                                begin
                                    msg_left_next = sw[15:0];
                                end
                                else if (pos_reg == POS_COOKIE_LO && sw != MAGIC_COOKIE)
                                begin
                                    phase_next   = PH_FINISHED;
                                    verdict_next = VERDICT_HEADER;
                                end
                                else if (pos_reg == POS_HEADER_END)
                                begin
                                    if ((msg_left_reg & ALIGN_MASK) != 16'd0)
                                    begin
                                        phase_next   = PH_FINISHED;
                                        verdict_next = VERDICT_NO_ADDR;
                                    end
                                    else
                                    begin
                                        walk_on = 1'b1;
                                    end
                                end
                                else
                                begin
                                end
                            end
                            PH_ATTR_HDR:
                            begin
                                attr_left_next = al;
                                if (al == 16'd0)
                                begin
                                    attr_type_next = sw[31:16];
                                    msg_left_next  = ml4;
                                    if ((len & ALIGN_MASK) != 16'd0 || len > ml4)
                                    begin
                                        phase_next   = PH_FINISHED;
                                        verdict_next = VERDICT_ATTR_LEN;
                                    end
                                    else
                                    begin
                                        msg_left_next = ml4 - len;
                                        if (sw[31:16] == ATTR_MAPPED && len == MAPPED_BYTES)
                                        begin
                                            phase_next     = PH_ATTR_MAPPED;
                                            attr_left_next = MAPPED_BYTES;
                                        end
                                        else if (len == 16'd0)
                                        begin
                                            walk_on   = 1'b1;
                                            walk_left = ml4;
                                        end
                                        else
                                        begin
                                            phase_next     = PH_ATTR_SKIP;
                                            attr_left_next = len;
                                        end
                                    end
                                end
                            end
                            PH_ATTR_SKIP:
                            begin
                                attr_left_next = al;
                                if (al == 16'd0)
                                    walk_on = 1'b1;
                            end
                            PH_ATTR_MAPPED:
                            begin
                                // hold the port in the type register until the end
                                if (attr_left_reg == MAPPED_PORT_AT)
                                    attr_type_next = sw[15:0];
                                attr_left_next = al;
                                if (al == 16'd0)
                                begin
                                    port_next      = attr_type_reg;
                                    addr_next      = sw;
                                    responded_next = 1'b1;
                                    phase_next     = PH_FINISHED;
                                    verdict_next   = VERDICT_CAPTURED;
                                end
                            end
                            default:
                            begin
                                phase_next   = PH_FINISHED;
                                verdict_next = VERDICT_IDLE;
                            end
                        endcase

                        // advance to the next attribute header if one fits
                        if (walk_on)
                        begin
                            if (walk_left < ATTR_HDR_BYTES)
                            begin
                                phase_next   = PH_FINISHED;
                                verdict_next = VERDICT_NO_ADDR;
                            end
                            else
                            begin
                                phase_next     = PH_ATTR_HDR;
                                attr_left_next = ATTR_HDR_BYTES;
                            end
                        end
                    end

                    if (req.last_byte)
                    begin
                        res_valid         = 1'b1;
                        res.verdict       = verdict_next;
                        res.address_valid = responded_next;
                        res.mapped_port   = responded_next ? port_next : 16'd0;
                        res.mapped_ipv4   = responded_next ? addr_next : 32'd0;
                        pos_next          = '0;
                        phase_next        = PH_HEADER;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            responded_reg <= 1'b0;
            pos_reg       <= '0;
            msg_left_reg  <= '0;
            attr_type_reg <= '0;
            attr_left_reg <= '0;
            phase_reg     <= PH_HEADER;
            shift_reg     <= '0;
            port_reg      <= '0;
            addr_reg      <= '0;
            verdict_reg   <= VERDICT_IDLE;
        end
        else
        begin
            pending_reg   <= pending_next;
            responded_reg <= responded_next;
            pos_reg       <= pos_next;
            msg_left_reg  <= msg_left_next;
            attr_type_reg <= attr_type_next;
            attr_left_reg <= attr_left_next;
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            port_reg      <= port_next;
            addr_reg      <= addr_next;
            verdict_reg   <= verdict_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/stun_mapped_address_parser.sv =====
// A result is registered once its last datagram byte is accepted.
// Throughput: one request per cycle unless stalled; single-pass parse update.
// A two-entry result buffer (output plus skid register) lets requests flow on
// while a result waits; request stall rises only when both entries are full.
// Reset (rst_n low, asynchronous) clears the parse state, held address and buffer.
`default_nettype none
`include "stun_mapped_address_parser_defines.svh"
module stun_mapped_address_parser (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire smap_pkg::in_t  req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output smap_pkg::out_t      rsp
);
    import smap_pkg::*;

    logic  take;
    logic  res_valid;
    out_t  res;

    logic  out_valid_reg,  out_valid_next;
    out_t  out_reg,        out_next;
    logic  skid_valid_reg, skid_valid_next;
    out_t  skid_reg,       skid_next;
    logic  drain;

    // Accept a request whenever the skid entry is free.
    assign req_stall = skid_valid_reg;
    assign take      = req_valid && !req_stall;

    // Parse state: header check, attribute walk, address capture.
    smap_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .req       (req),
        .res_valid (res_valid),
        .res       (res)
    );

    assign drain = out_valid_reg && !rsp_stall;

    // Result buffer: the output register feeds the port, the skid register
    // catches a result produced while the output is stalled.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            // no new result can arrive here: requests are stalled
            if (drain)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || drain)
            begin
                out_valid_next = 1'b1;
                out_next       = res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = res;
            end
        end
        else if (drain)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // The skid entry is only ever filled behind a held result.
    `SMAP_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    // A result without a held address shows a zero port and address.
    `SMAP_ASSERT_IMP(a_zero_when_unheld, out_valid_reg && !out_reg.address_valid,
                     out_reg.mapped_port == 16'd0 && out_reg.mapped_ipv4 == 32'd0)
    // A capture verdict always comes with a held address.
    `SMAP_ASSERT_IMP(a_capture_holds, out_valid_reg && out_reg.verdict == VERDICT_CAPTURED,
                     out_reg.address_valid)
    // A stalled result stays in place.
    `SMAP_ASSERT_NEXT(a_stalled_out_kept, out_valid_reg && rsp_stall,
                      out_valid_reg && $stable(out_reg))

endmodule
`default_nettype wire
